### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/wsr_pkg.sv
package wsr_pkg;

   typedef enum logic [2:0] {
      ACT_PULSE    = 3'd0,
      ACT_SAMPLE   = 3'd1,
      ACT_RAMP     = 3'd2,
      ACT_START    = 3'd3,
      ACT_END_UP   = 3'd4,
      ACT_END_DOWN = 3'd5,
      ACT_STOP     = 3'd6
   } action_type;

   localparam logic [1:0] MODE_STOP    = 2'd0;
   localparam logic [1:0] MODE_FORWARD = 2'd1;
   localparam logic [1:0] MODE_REVERSE = 2'd2;

   localparam logic [7:0] DUTY_MIN   = 8'h20;
   localparam logic [7:0] DUTY_MAX   = 8'hFB;
   localparam logic [7:0] DUTY_START = 8'hA0;
   localparam logic [7:0] END_HIGH   = 8'd20;
   localparam logic [7:0] END_LOW    = 8'd2;

   // Current drive state as seen by the measurement path.
   typedef struct packed {
      logic       halted;
      logic [1:0] drive_mode;
   } ctl_state_type;

   // Averaging event raised by the measurement path.
   typedef struct packed {
      logic       avg_event;
      logic [7:0] avg_value;
   } meas_event_type;

   // Values of the controller state after the current transaction.
   typedef struct packed {
      logic [7:0] pwm_duty;
      logic       pwm_enable;
      logic [1:0] drive_mode;
      logic [7:0] run_target;
   } ctl_view_type;

   function automatic logic [2:0] step_size(input logic [7:0] err);
      logic [2:0] s;
      if (err > 8'd3) begin
         s = 3'd4;
      end else if (err > 8'd2) begin
         s = 3'd3;
      end else if (err > 8'd1) begin
         s = 3'd2;
      end else begin
         s = 3'd1;
      end
      return s;
   endfunction

endpackage

### rtl/wsr_measure.sv
module wsr_measure (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  wsr_pkg::action_type     action,
   input  wsr_pkg::ctl_state_type  ctl,
   output wsr_pkg::meas_event_type meas
);

   logic [15:0] pulse_count_ff, pulse_count_in;
   logic [15:0] last_count_ff, last_count_in;
   logic [7:0]  sample0_ff, sample0_in;
   logic [7:0]  sample1_ff, sample1_in;
   logic        phase_ff, phase_in;
   logic [7:0]  avg_ff, avg_in;

   logic [16:0] fwd_diff;
   logic [16:0] rev_diff;
   logic [7:0]  new_sample;
   logic        take_sample;
   logic [8:0]  sum;
   logic        avg_event;

   // Sign-extended differences; the sign bit tells whether the count moved the right way.
   assign fwd_diff = {pulse_count_ff[15], pulse_count_ff} - {last_count_ff[15], last_count_ff};
   assign rev_diff = {last_count_ff[15], last_count_ff} - {pulse_count_ff[15], pulse_count_ff};

   always_comb begin
      take_sample = 1'b0;
      new_sample  = fwd_diff[7:0];
      if (!ctl.halted && ctl.drive_mode == wsr_pkg::MODE_FORWARD && !fwd_diff[16]) begin
         take_sample = 1'b1;
         new_sample  = fwd_diff[7:0];
      end else if (!ctl.halted && ctl.drive_mode == wsr_pkg::MODE_REVERSE &&
                   !rev_diff[16]) begin
         take_sample = 1'b1;
         new_sample  = rev_diff[7:0];
      end
   end

   always_comb begin
      pulse_count_in = pulse_count_ff;
      last_count_in  = last_count_ff;
      sample0_in     = sample0_ff;
      sample1_in     = sample1_ff;
      phase_in       = phase_ff;
      avg_event      = 1'b0;
      if (go) begin
         case (action)
            wsr_pkg::ACT_PULSE: begin
               if (ctl.drive_mode == wsr_pkg::MODE_FORWARD) begin
                  pulse_count_in = pulse_count_ff + 16'd1;
               end else if (ctl.drive_mode == wsr_pkg::MODE_REVERSE) begin
                  pulse_count_in = pulse_count_ff - 16'd1;
               end
            end
            wsr_pkg::ACT_SAMPLE: begin
               if (take_sample && !phase_ff) begin
                  sample0_in = new_sample;
               end
               if (take_sample && phase_ff) begin
                  sample1_in = new_sample;
               end
               last_count_in = pulse_count_ff;
               phase_in      = !phase_ff;
               avg_event     = phase_ff;
            end
            wsr_pkg::ACT_START, wsr_pkg::ACT_END_UP, wsr_pkg::ACT_END_DOWN: begin
               pulse_count_in = '0;
               last_count_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign sum = {1'b0, sample0_in} + {1'b0, sample1_in};

   always_comb begin
      avg_in = avg_ff;
      if (avg_event) begin
         avg_in = sum[8:1];
      end
   end

   assign meas.avg_event = avg_event;
   assign meas.avg_value = avg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff <= '0;
         last_count_ff  <= '0;
         sample0_ff     <= '0;
         sample1_ff     <= '0;
         phase_ff       <= 1'b0;
         avg_ff         <= '0;
      end else begin
         pulse_count_ff <= pulse_count_in;
         last_count_ff  <= last_count_in;
         sample0_ff     <= sample0_in;
         sample1_ff     <= sample1_in;
         phase_ff       <= phase_in;
         avg_ff         <= avg_in;
      end
   end

endmodule

### rtl/wsr_control.sv
module wsr_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  wsr_pkg::action_type     action,
   input  logic [1:0]              direction,
   input  logic [7:0]              start_speed,
   input  logic [7:0]              end_speed,
   input  logic [7:0]              ramp_slope,
   input  wsr_pkg::meas_event_type meas,
   output wsr_pkg::ctl_state_type  ctl,
   output wsr_pkg::ctl_view_type   view
);

   logic [7:0] run_target_ff, run_target_in;
   logic [7:0] final_target_ff, final_target_in;
   logic [7:0] slope_ff, slope_in;
   logic [7:0] ramp_timer_ff, ramp_timer_in;
   logic [7:0] duty_ff, duty_in;
   logic [1:0] mode_ff, mode_in;
   logic       halted_ff, halted_in;
   logic [7:0] pwm_duty_ff, pwm_duty_in;
   logic       pwm_enable_ff, pwm_enable_in;

   logic [7:0] reg_duty;
   logic       reg_halted;
   logic [2:0] dn_step;
   logic [2:0] up_step;
   logic [8:0] up_sum;
   logic [7:0] timer_inc;

   assign dn_step   = wsr_pkg::step_size(meas.avg_value - run_target_ff);
   assign up_step   = wsr_pkg::step_size(run_target_ff - meas.avg_value);
   assign up_sum    = {1'b0, duty_ff} + {6'b0, up_step};
   assign timer_inc = ramp_timer_ff + 8'd1;

   // Duty regulation on an averaging event, using the freshly averaged speed.
   always_comb begin
      reg_duty   = duty_ff;
      reg_halted = halted_ff;
      if (halted_ff) begin
         reg_duty = '0;
      end else if (run_target_ff == 8'd0) begin
         reg_duty   = '0;
         reg_halted = 1'b1;
      end else if (meas.avg_value > run_target_ff) begin
         if ({1'b0, duty_ff} < ({1'b0, wsr_pkg::DUTY_MIN} + {6'b0, dn_step})) begin
            reg_duty = wsr_pkg::DUTY_MIN;
         end else begin
            reg_duty = duty_ff - {5'b0, dn_step};
         end
      end else if (meas.avg_value < run_target_ff) begin
         if (up_sum > {1'b0, wsr_pkg::DUTY_MAX}) begin
            reg_duty = wsr_pkg::DUTY_MAX;
         end else begin
            reg_duty = up_sum[7:0];
         end
      end
   end

   always_comb begin
      run_target_in   = run_target_ff;
      final_target_in = final_target_ff;
      slope_in        = slope_ff;
      ramp_timer_in   = ramp_timer_ff;
      duty_in         = duty_ff;
      mode_in         = mode_ff;
      halted_in       = halted_ff;
      pwm_duty_in     = pwm_duty_ff;
      pwm_enable_in   = pwm_enable_ff;
      if (go) begin
         case (action)
            wsr_pkg::ACT_SAMPLE: begin
               if (meas.avg_event) begin
                  duty_in   = reg_duty;
                  halted_in = reg_halted;
                  if (reg_halted || mode_ff != wsr_pkg::MODE_STOP) begin
                     pwm_duty_in = reg_duty;
                  end else begin
                     pwm_enable_in = 1'b0;
                  end
               end
            end
            wsr_pkg::ACT_RAMP: begin
               if (run_target_ff != final_target_ff) begin
                  if (timer_inc > slope_ff) begin
                     ramp_timer_in = '0;
                     if (run_target_ff > final_target_ff) begin
                        run_target_in = run_target_ff - 8'd1;
                     end else begin
                        run_target_in = run_target_ff + 8'd1;
                     end
                  end else begin
                     ramp_timer_in = timer_inc;
                  end
               end
            end
            wsr_pkg::ACT_START: begin
               slope_in = ramp_slope;
               if (direction == wsr_pkg::MODE_FORWARD || direction == wsr_pkg::MODE_REVERSE) begin
                  duty_in       = wsr_pkg::DUTY_START;
                  pwm_duty_in   = wsr_pkg::DUTY_START;
                  pwm_enable_in = 1'b1;
                  mode_in       = direction;
                  halted_in     = 1'b0;
               end else begin
                  pwm_enable_in = 1'b0;
               end
               run_target_in   = start_speed;
               final_target_in = end_speed;
            end
            wsr_pkg::ACT_END_UP: begin
               slope_in = ramp_slope;
               if (final_target_ff < wsr_pkg::END_HIGH) begin
                  final_target_in = final_target_ff + 8'd1;
               end
            end
            wsr_pkg::ACT_END_DOWN: begin
               slope_in = ramp_slope;
               if (final_target_ff > wsr_pkg::END_LOW) begin
                  final_target_in = final_target_ff - 8'd1;
               end
            end
            wsr_pkg::ACT_STOP: begin
               pwm_enable_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign ctl.halted     = halted_ff;
   assign ctl.drive_mode = mode_ff;

   assign view.pwm_duty   = pwm_duty_in;
   assign view.pwm_enable = pwm_enable_in;
   assign view.drive_mode = mode_in;
   assign view.run_target = run_target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_target_ff   <= '0;
         final_target_ff <= '0;
         slope_ff        <= '0;
         ramp_timer_ff   <= '0;
         duty_ff         <= '0;
         mode_ff         <= wsr_pkg::MODE_STOP;
         halted_ff       <= 1'b0;
         pwm_duty_ff     <= '0;
         pwm_enable_ff   <= 1'b0;
      end else begin
         run_target_ff   <= run_target_in;
         final_target_ff <= final_target_in;
         slope_ff        <= slope_in;
         ramp_timer_ff   <= ramp_timer_in;
         duty_ff         <= duty_in;
         mode_ff         <= mode_in;
         halted_ff       <= halted_in;
         pwm_duty_ff     <= pwm_duty_in;
         pwm_enable_ff   <= pwm_enable_in;
      end
   end

endmodule

### rtl/wheel_speed_regulator.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  action, direction, start/end speed, ramp slope
// rsp_      out        rsp_valid / rsp_ready  duty, drive_on/dir, average and target speed
//
// One transaction is accepted per cycle while the result is not stalled; its result is
// offered from the result register that follows the input register.
// The state update for a transaction is done in the cycle it leaves the input register.
// Reset is synchronous and clears all regulator state and both valid flags.
// A stalled result holds the input register; once both are full, req_ready stays low
// until the result is taken.
module wheel_speed_regulator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [1:0] req_direction,
   input  logic [7:0] req_start_speed,
   input  logic [7:0] req_end_speed,
   input  logic [7:0] req_ramp_slope,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_duty,
   output logic       rsp_drive_on,
   output logic [1:0] rsp_drive_dir,
   output logic [7:0] rsp_average_speed,
   output logic [7:0] rsp_target_speed
);

   logic                in_valid_ff, in_valid_in;
   wsr_pkg::action_type action_ff;
   logic [1:0]          direction_ff;
   logic [7:0]          start_speed_ff;
   logic [7:0]          end_speed_ff;
   logic [7:0]          ramp_slope_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          duty_ff;
   logic                drive_on_ff;
   logic [1:0]          drive_dir_ff;
   logic [7:0]          avg_ff;
   logic [7:0]          target_ff;

   logic                advance;
   logic                go;
   logic                take;

   wsr_pkg::ctl_state_type  ctl;
   wsr_pkg::meas_event_type meas;
   wsr_pkg::ctl_view_type   view;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign go        = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = go || (rsp_valid_ff && !rsp_ready);

   wsr_measure u_measure (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .action (action_ff),
      .ctl    (ctl),
      .meas   (meas)
   );

   wsr_control u_control (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .action      (action_ff),
      .direction   (direction_ff),
      .start_speed (start_speed_ff),
      .end_speed   (end_speed_ff),
      .ramp_slope  (ramp_slope_ff),
      .meas        (meas),
      .ctl         (ctl),
      .view        (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff      <= wsr_pkg::action_type'(req_action);
         direction_ff   <= req_direction;
         start_speed_ff <= req_start_speed;
         end_speed_ff   <= req_end_speed;
         ramp_slope_ff  <= req_ramp_slope;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         duty_ff      <= view.pwm_duty;
         drive_on_ff  <= view.pwm_enable;
         drive_dir_ff <= view.pwm_enable ? view.drive_mode : wsr_pkg::MODE_STOP;
         avg_ff       <= meas.avg_value;
         target_ff    <= view.run_target;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty          = duty_ff;
   assign rsp_drive_on      = drive_on_ff;
   assign rsp_drive_dir     = drive_dir_ff;
   assign rsp_average_speed = avg_ff;
   assign rsp_target_speed  = target_ff;

endmodule

### rtl/wsr_checker.sv
`include "assert_macros.svh"

module wsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_duty,
   input logic       rsp_drive_on,
   input logic [1:0] rsp_drive_dir
);

   // A result that is not taken must stay offered.
   `ASSERT_NEXT(rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A direction is only reported while the bridge is enabled.
   `ASSERT_IMPLIES(dir_needs_on, clock, reset, rsp_valid && !rsp_drive_on,
                   rsp_drive_dir == wsr_pkg::MODE_STOP)

   // The direction code is never the unused fourth value.
   `ASSERT_IMPLIES(dir_legal, clock, reset, rsp_valid, rsp_drive_dir != 2'd3)

   // The duty is either zero or inside the regulation window.
   `ASSERT_IMPLIES(duty_window, clock, reset, rsp_valid,
                   rsp_duty == 8'd0 ||
                   (rsp_duty >= wsr_pkg::DUTY_MIN && rsp_duty <= wsr_pkg::DUTY_MAX))

endmodule

bind wheel_speed_regulator wsr_checker u_wsr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_duty      (rsp_duty),
   .rsp_drive_on  (rsp_drive_on),
   .rsp_drive_dir (rsp_drive_dir)
);

### tb/sv/wheel_speed_regulator_tb.sv
`timescale 1ns / 1ps

module wheel_speed_regulator_tb;

   localparam int CLK_PERIOD = 10;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 1700;
   // Action code that the block has no meaning for; it only reports its state.
   localparam logic [2:0] ACT_SPARE = 3'd7;

   typedef struct packed {
      logic [7:0] duty;
      logic       drive_on;
      logic [1:0] drive_dir;
      logic [7:0] average_speed;
      logic [7:0] target_speed;
   } wheel_view_type;

   class regulator_scoreboard;
      bit [15:0]      pulse_count;
      bit [15:0]      last_count;
      bit [7:0]       sample_buf [2];
      bit             sample_phase;
      bit [7:0]       avg_speed;
      bit [7:0]       run_target;
      bit [7:0]       final_target;
      bit [7:0]       slope_setting;
      bit [7:0]       ramp_timer;
      bit [7:0]       duty_reg;
      bit [1:0]       drive_mode;
      bit             halted;
      bit [7:0]       pwm_duty;
      bit             pwm_on;
      wheel_view_type expected_q [$];
      int             errors;
      int             items;
      int             results;
      int             min_hits;
      int             max_hits;
      int             halt_hits;

      function int duty_step(bit [7:0] err);
         return (err > 8'd3) ? 4 : int'(err);
      endfunction

      function void note_request(logic [2:0] action, logic [1:0] dir, logic [7:0] start_speed,
                                 logic [7:0] end_speed, logic [7:0] slope);
         int             now_cnt;
         int             last_cnt;
         int             next_duty;
         wheel_view_type view;
         items++;
         case (action)
            wsr_pkg::ACT_PULSE: begin
               if (drive_mode == wsr_pkg::MODE_FORWARD) begin
                  pulse_count++;
               end else if (drive_mode == wsr_pkg::MODE_REVERSE) begin
                  pulse_count--;
               end
            end
            wsr_pkg::ACT_SAMPLE: begin
               now_cnt = $signed(pulse_count);
               last_cnt = $signed(last_count);
               // A sample is kept only if the count moved in the driven direction.
               if (!halted && drive_mode == wsr_pkg::MODE_FORWARD && now_cnt >= last_cnt) begin
                  sample_buf[sample_phase] = 8'(now_cnt - last_cnt);
               end else if (!halted && drive_mode == wsr_pkg::MODE_REVERSE &&
                            last_cnt >= now_cnt) begin
                  sample_buf[sample_phase] = 8'(last_cnt - now_cnt);
               end
               last_count = pulse_count;
               if (!sample_phase) begin
                  sample_phase = 1'b1;
               end else begin
                  sample_phase = 1'b0;
                  avg_speed = 8'((9'(sample_buf[0]) + 9'(sample_buf[1])) >> 1);
                  if (halted) begin
                     duty_reg = 8'd0;
                  end else if (run_target == 8'd0) begin
                     duty_reg = 8'd0;
                     halted = 1'b1;
                     halt_hits++;
                  end else if (avg_speed > run_target) begin
                     next_duty = int'(duty_reg) - duty_step(avg_speed - run_target);
                     if (next_duty < int'(wsr_pkg::DUTY_MIN)) begin
                        duty_reg = wsr_pkg::DUTY_MIN;
                        min_hits++;
                     end else begin
                        duty_reg = 8'(next_duty);
                     end
                  end else if (avg_speed < run_target) begin
                     next_duty = int'(duty_reg) + duty_step(run_target - avg_speed);
                     if (next_duty > int'(wsr_pkg::DUTY_MAX)) begin
                        duty_reg = wsr_pkg::DUTY_MAX;
                        max_hits++;
                     end else begin
                        duty_reg = 8'(next_duty);
                     end
                  end
                  if (halted || drive_mode != wsr_pkg::MODE_STOP) begin
                     pwm_duty = duty_reg;
                  end else begin
                     pwm_on = 1'b0;
                  end
               end
            end
            wsr_pkg::ACT_RAMP: begin
               if (run_target != final_target) begin
                  ramp_timer++;
                  if (ramp_timer > slope_setting) begin
                     ramp_timer = 8'd0;
                     if (run_target > final_target) begin
                        run_target--;
                     end else begin
                        run_target++;
                     end
                  end
               end
            end
            wsr_pkg::ACT_START, wsr_pkg::ACT_END_UP, wsr_pkg::ACT_END_DOWN: begin
               pulse_count = 16'd0;
               last_count = 16'd0;
               slope_setting = slope;
               if (action == wsr_pkg::ACT_END_UP) begin
                  if (final_target < wsr_pkg::END_HIGH) begin
                     final_target++;
                  end
               end else if (action == wsr_pkg::ACT_END_DOWN) begin
                  if (final_target > wsr_pkg::END_LOW) begin
                     final_target--;
                  end
               end else begin
                  if (dir == wsr_pkg::MODE_FORWARD || dir == wsr_pkg::MODE_REVERSE) begin
                     duty_reg = wsr_pkg::DUTY_START;
                     pwm_duty = wsr_pkg::DUTY_START;
                     pwm_on = 1'b1;
                     drive_mode = dir;
                     halted = 1'b0;
                  end else begin
                     pwm_on = 1'b0;
                  end
                  run_target = start_speed;
                  final_target = end_speed;
               end
            end
            wsr_pkg::ACT_STOP: begin
               pwm_on = 1'b0;
            end
            default: begin
            end
         endcase
         view.duty = pwm_duty;
         view.drive_on = pwm_on;
         view.drive_dir = pwm_on ? drive_mode : wsr_pkg::MODE_STOP;
         view.average_speed = avg_speed;
         view.target_speed = run_target;
         expected_q.push_back(view);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [7:0] duty, logic drive_on, logic [1:0] drive_dir,
                                   logic [7:0] average_speed, logic [7:0] target_speed);
         wheel_view_type want;
         results++;
         if (expected_q.size() == 0) begin
            $error("result transaction arrived with nothing expected");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("duty", want.duty, duty);
         compare_field("drive_on", 8'(want.drive_on), 8'(drive_on));
         compare_field("drive_dir", 8'(want.drive_dir), 8'(drive_dir));
         compare_field("average_speed", want.average_speed, average_speed);
         compare_field("target_speed", want.target_speed, target_speed);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = ACT_SPARE;
   logic [1:0] req_direction = 2'd0;
   logic [7:0] req_start_speed = 8'd0;
   logic [7:0] req_end_speed = 8'd0;
   logic [7:0] req_ramp_slope = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_duty;
   logic       rsp_drive_on;
   logic [1:0] rsp_drive_dir;
   logic [7:0] rsp_average_speed;
   logic [7:0] rsp_target_speed;

   regulator_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent_count = 0;
   int quiet_cycles = 0;

   wheel_speed_regulator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_direction     (req_direction),
      .req_start_speed   (req_start_speed),
      .req_end_speed     (req_end_speed),
      .req_ramp_slope    (req_ramp_slope),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_duty          (rsp_duty),
      .rsp_drive_on      (rsp_drive_on),
      .rsp_drive_dir     (rsp_drive_dir),
      .rsp_average_speed (rsp_average_speed),
      .rsp_target_speed  (rsp_target_speed)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Handshakes are sampled at the falling edge, where all signals are settled;
   // a transaction seen here completes at the following rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_action, req_direction, req_start_speed, req_end_speed,
                            req_ramp_slope);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_duty, rsp_drive_on, rsp_drive_dir, rsp_average_speed,
                              rsp_target_speed);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [2:0] action, input logic [1:0] dir,
                            input logic [7:0] start_speed, input logic [7:0] end_speed,
                            input logic [7:0] slope);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_direction <= dir;
      req_start_speed <= start_speed;
      req_end_speed <= end_speed;
      req_ramp_slope <= slope;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   // Fields that the action ignores still carry random values.
   task automatic send_event(input logic [2:0] action);
      send_item(action, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   function automatic logic [7:0] pick_speed();
      case ($urandom_range(3))
         0: return 8'($urandom_range(0, 3));
         1: return 8'($urandom_range(4, 30));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One drive session: a start, then counting windows each closed by a sample tick,
   // with ramp ticks, end speed nudges, stops and noise mixed in.
   task automatic run_session();
      logic [1:0] dir;
      int         windows;
      int         pulse_max;
      int         pulses;
      dir = ($urandom_range(7) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
      send_item(wsr_pkg::ACT_START, dir, pick_speed(), pick_speed(),
                ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(0, 3)));
      case ($urandom_range(2))
         0: pulse_max = 2;
         1: pulse_max = 8;
         default: pulse_max = 20;
      endcase
      windows = $urandom_range(4, 60);
      repeat (windows) begin
         pulses = ($urandom_range(39) == 0) ? $urandom_range(250, 300)
                                            : $urandom_range(0, pulse_max);
         repeat (pulses) send_event(wsr_pkg::ACT_PULSE);
         send_event(wsr_pkg::ACT_SAMPLE);
         case ($urandom_range(31))
            0, 1, 2, 3: repeat ($urandom_range(1, 4)) send_event(wsr_pkg::ACT_RAMP);
            4: send_item(wsr_pkg::ACT_END_UP, 2'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(0, 3)));
            5: send_item(wsr_pkg::ACT_END_DOWN, 2'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(0, 3)));
            6: send_event(wsr_pkg::ACT_STOP);
            7: send_event(3'($urandom));
            default: begin
            end
         endcase
      end
   endtask

   initial begin
      int send_pcts [4];
      int recv_pcts [4];
      int random_base;
      send_pcts = '{0, 49, 0, 29};
      recv_pcts = '{0, 0, 49, 29};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      send_event(ACT_SPARE);
      send_event(wsr_pkg::ACT_PULSE);
      // Averaging while stopped with a zero target halts the drive.
      send_event(wsr_pkg::ACT_SAMPLE);
      send_event(wsr_pkg::ACT_SAMPLE);
      send_item(wsr_pkg::ACT_START, wsr_pkg::MODE_STOP, 8'd20, 8'd30, 8'd0);
      send_item(wsr_pkg::ACT_START, wsr_pkg::MODE_FORWARD, 8'hFF, 8'h00, 8'h00);
      repeat (3) send_event(wsr_pkg::ACT_PULSE);
      send_event(wsr_pkg::ACT_SAMPLE);
      send_event(wsr_pkg::ACT_SAMPLE);
      send_event(wsr_pkg::ACT_RAMP);
      send_item(wsr_pkg::ACT_END_UP, 2'd3, 8'hFF, 8'hFF, 8'hFF);
      send_event(wsr_pkg::ACT_RAMP);
      send_item(wsr_pkg::ACT_END_DOWN, 2'd0, 8'h00, 8'h00, 8'h00);
      send_event(wsr_pkg::ACT_STOP);
      send_item(wsr_pkg::ACT_START, wsr_pkg::MODE_REVERSE, 8'd0, 8'd0, 8'd0);
      send_event(wsr_pkg::ACT_PULSE);
      send_event(wsr_pkg::ACT_SAMPLE);
      send_event(wsr_pkg::ACT_SAMPLE);
      send_item(wsr_pkg::ACT_START, 2'd3, 8'd239, 8'd20, 8'hFF);
      send_item(wsr_pkg::ACT_START, wsr_pkg::MODE_FORWARD, 8'd5, 8'd20, 8'd0);
      send_item(wsr_pkg::ACT_END_UP, 2'd1, 8'd0, 8'd0, 8'd0);
      send_item(wsr_pkg::ACT_START, wsr_pkg::MODE_FORWARD, 8'd1, 8'd2, 8'd0);
      send_item(wsr_pkg::ACT_END_DOWN, 2'd2, 8'd0, 8'd0, 8'd0);

      // Random part, in four idling phases.
      random_base = sent_count;
      for (int k = 0; k < 4; k++) begin
         send_idle_pct = send_pcts[k];
         recv_stall_pct = recv_pcts[k];
         while (sent_count < random_base + RANDOM_ITEMS * (k + 1) / 4) begin
            run_session();
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d transactions and %0d results under four idling mixes.",
               sb.items, sb.results);
      $display("Duty hit the lower limit %0d times, the upper limit %0d times; %0d halts.",
               sb.min_hits, sb.max_hits, sb.halt_hits);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
